FILE: src/wts_pkg.sv
// shared types and constants for the wheel turn sequencer
package wts_pkg;

  // travel counts and bases wrap at this width
  localparam int TRAVEL_W = 32;
  // width used for exact compares of travel against base +/- amount
  localparam int CMP_W    = TRAVEL_W + 2;

  // field widths
  localparam int ANGLE_W  = 32;
  localparam int AMOUNT_W = 16;
  localparam int SPEED_W  = 7;
  localparam int DRIVE_W  = 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // highest drive magnitude
  localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TURN_KIND      = 2'd0,
    REG_TURN_DIRECTION = 2'd1,
    REG_TURN_AMOUNT    = 2'd2,
    REG_DRIVE_SPEED    = 2'd3
  } reg_index_t;

  // turn kinds
  typedef enum logic {
    KIND_SPIN  = 1'b0,
    KIND_PIVOT = 1'b1
  } turn_kind_t;

  // turn directions
  typedef enum logic {
    DIR_RIGHT = 1'b0,
    DIR_LEFT  = 1'b1
  } turn_dir_t;

  // result beat fields
  typedef struct packed {
    logic                      turn_done;
    logic signed [DRIVE_W-1:0] right_drive;
    logic signed [DRIVE_W-1:0] left_drive;
  } result_t;

endpackage

FILE: src/wheel_turn_sequencer.sv
// wheel turn sequencer top level: odometry, turn base latch, drive and done logic
// an input beat passes two registers on its way to its result beat: input register, result register
// throughput: one beat per cycle; while a result waits one more input beat is held, then stall
// the odometry state is updated at the cycle an item moves from input to result register
// reset (rst, synchronous): configuration registers zero, travel counts zero, turn not armed, no beats held
// configuration writes take effect at the clock edge of the write
module wheel_turn_sequencer #(
  parameter int ANGLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic [wts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wts_pkg::CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // left_angle [31:0], right_angle [63:32]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // left_drive [7:0], right_drive [15:8], turn_done [16], zero
);

  localparam int TW = wts_pkg::TRAVEL_W;
  localparam int CW = wts_pkg::CMP_W;

  // configuration registers
  logic                          turn_kind;
  logic                          turn_direction;
  logic [wts_pkg::AMOUNT_W-1:0]  turn_amount;
  logic [wts_pkg::SPEED_W-1:0]   drive_speed;

  // input register
  logic                          in_valid;
  logic [wts_pkg::ANGLE_W-1:0]   in_left;
  logic [wts_pkg::ANGLE_W-1:0]   in_right;

  // odometry state
  logic [ANGLE_BITS-1:0]         prev_left;
  logic [ANGLE_BITS-1:0]         prev_right;
  logic [TW-1:0]                 left_travel;
  logic [TW-1:0]                 right_travel;
  logic [TW-1:0]                 left_base;
  logic [TW-1:0]                 right_base;
  logic                          armed;

  // result register
  logic                          out_valid;
  wts_pkg::result_t              result;

  // datapath
  logic                          step;
  logic [ANGLE_BITS-1:0]         cur_left;
  logic [ANGLE_BITS-1:0]         cur_right;
  logic signed [ANGLE_BITS-1:0]  left_delta;
  logic signed [ANGLE_BITS-1:0]  right_delta;
  logic [TW-1:0]                 left_travel_next;
  logic [TW-1:0]                 right_travel_next;
  logic [TW-1:0]                 left_base_next;
  logic [TW-1:0]                 right_base_next;
  logic signed [CW-1:0]          lt;
  logic signed [CW-1:0]          rt;
  logic signed [CW-1:0]          lb;
  logic signed [CW-1:0]          rb;
  logic signed [CW-1:0]          thr;
  logic                          l_past_fwd;
  logic                          l_past_back;
  logic                          r_past_fwd;
  logic                          r_past_back;
  logic [wts_pkg::SPEED_W-1:0]   speed;
  logic signed [wts_pkg::DRIVE_W-1:0] speed_pos;
  logic signed [wts_pkg::DRIVE_W-1:0] speed_neg;
  wts_pkg::result_t              result_next;

  // handshake: result register frees when empty or taken, input register refills behind it
  assign step     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || step;
  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, result};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      turn_kind      <= 1'b0;
      turn_direction <= 1'b0;
      turn_amount    <= '0;
      drive_speed    <= '0;
    end else if (cfg_we) begin
      unique case (wts_pkg::reg_index_t'(cfg_index))
        wts_pkg::REG_TURN_KIND:      turn_kind      <= cfg_data[0];
        wts_pkg::REG_TURN_DIRECTION: turn_direction <= cfg_data[0];
        wts_pkg::REG_TURN_AMOUNT:    turn_amount    <= cfg_data[wts_pkg::AMOUNT_W-1:0];
        wts_pkg::REG_DRIVE_SPEED:    drive_speed    <= cfg_data[wts_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_left  <= s_tdata[31:0];
      in_right <= s_tdata[63:32];
    end
  end

  // per-tick change, modulo the angle width, folded into the wrapping travel counts
  always_comb begin
    cur_left          = in_left[ANGLE_BITS-1:0];
    cur_right         = in_right[ANGLE_BITS-1:0];
    left_delta        = cur_left - prev_left;
    right_delta       = cur_right - prev_right;
    left_travel_next  = left_travel + TW'(left_delta);
    right_travel_next = right_travel + TW'(right_delta);
    left_base_next    = armed ? left_base  : left_travel_next;
    right_base_next   = armed ? right_base : right_travel_next;
  end

  // exact signed compares against base +/- amount
  always_comb begin
    lt  = CW'(signed'(left_travel_next));
    rt  = CW'(signed'(right_travel_next));
    lb  = CW'(signed'(left_base_next));
    rb  = CW'(signed'(right_base_next));
    thr = signed'({{(CW-wts_pkg::AMOUNT_W){1'b0}}, turn_amount});
    l_past_fwd  = lt > (lb + thr);
    l_past_back = lt < (lb - thr);
    r_past_fwd  = rt > (rb + thr);
    r_past_back = rt < (rb - thr);
  end

  // drive commands and done
  always_comb begin
    speed     = (drive_speed > wts_pkg::SPEED_MAX) ? wts_pkg::SPEED_MAX : drive_speed;
    speed_pos = signed'({1'b0, speed});
    speed_neg = -speed_pos;
    result_next = '0;
    unique case ({wts_pkg::turn_kind_t'(turn_kind), wts_pkg::turn_dir_t'(turn_direction)})
      {wts_pkg::KIND_SPIN, wts_pkg::DIR_RIGHT}: begin
        result_next.left_drive  = l_past_fwd  ? '0 : speed_pos;
        result_next.right_drive = r_past_back ? '0 : speed_neg;
        result_next.turn_done   = l_past_fwd && r_past_back;
      end
      {wts_pkg::KIND_SPIN, wts_pkg::DIR_LEFT}: begin
        result_next.left_drive  = l_past_back ? '0 : speed_neg;
        result_next.right_drive = r_past_fwd  ? '0 : speed_pos;
        result_next.turn_done   = l_past_back && r_past_fwd;
      end
      {wts_pkg::KIND_PIVOT, wts_pkg::DIR_RIGHT}: begin
        result_next.left_drive  = l_past_fwd ? '0 : speed_pos;
        result_next.turn_done   = l_past_fwd;
      end
      default: begin
        result_next.right_drive = r_past_fwd ? '0 : speed_pos;
        result_next.turn_done   = r_past_fwd;
      end
    endcase
  end

  // odometry and turn state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left    <= '0;
      prev_right   <= '0;
      left_travel  <= '0;
      right_travel <= '0;
      left_base    <= '0;
      right_base   <= '0;
      armed        <= 1'b0;
    end else if (step) begin
      prev_left    <= cur_left;
      prev_right   <= cur_right;
      left_travel  <= left_travel_next;
      right_travel <= right_travel_next;
      left_base    <= left_base_next;
      right_base   <= right_base_next;
      armed        <= !result_next.turn_done;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_next;
    end
  end

endmodule

FILE: bench/turn_checker.sv
// turn checker: predicts each result beat of the wheel turn sequencer and compares it
`timescale 1ns / 100ps

module turn_checker #(
  parameter int ANGLE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [wts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wts_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // left_angle [31:0], right_angle [63:32]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,   // left_drive [7:0], right_drive [15:8], turn_done [16], zero
  output int          fails,
  output int          pending
);

  localparam longint ANGLE_MASK = (longint'(1) << ANGLE_BITS) - 1;
  localparam int TRAVEL_W = wts_pkg::TRAVEL_W;
  localparam int DRIVE_W  = wts_pkg::DRIVE_W;

  // shadow copy of the registers
  wts_pkg::turn_kind_t          kind_r;
  wts_pkg::turn_dir_t           dir_r;
  logic [wts_pkg::AMOUNT_W-1:0] amount_r;
  logic [wts_pkg::SPEED_W-1:0]  speed_r;

  // shadow copy of the odometry and turn state
  logic [TRAVEL_W-1:0] prev_left, prev_right;
  logic [TRAVEL_W-1:0] left_travel, right_travel;
  logic [TRAVEL_W-1:0] left_base, right_base;
  logic                armed;

  // drive and done values still owed by the block, oldest first
  wts_pkg::result_t turn_result_q[$];

  // change of one wheel since the last tick, read as signed at the angle width
  function automatic logic [TRAVEL_W-1:0] angle_delta(input logic [TRAVEL_W-1:0] prev,
                                                      input logic [wts_pkg::ANGLE_W-1:0] now);
    longint d;
    d = ((longint'(now) & ANGLE_MASK) - longint'(prev)) & ANGLE_MASK;
    if (d[ANGLE_BITS-1])
      d = d - (longint'(1) << ANGLE_BITS);
    return d[TRAVEL_W-1:0];
  endfunction

  always @(posedge clk) begin : watch
    longint  lt, rt, lb, rb, thr, spd, ld, rd;
    logic    l_fwd, l_back, r_fwd, r_back, done;
    wts_pkg::result_t want, got;
    if (rst) begin
      kind_r       = wts_pkg::KIND_SPIN;
      dir_r        = wts_pkg::DIR_RIGHT;
      amount_r     = '0;
      speed_r      = '0;
      prev_left    = '0;
      prev_right   = '0;
      left_travel  = '0;
      right_travel = '0;
      left_base    = '0;
      right_base   = '0;
      armed        = 1'b0;
      turn_result_q.delete();
      fails        = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (wts_pkg::reg_index_t'(cfg_index))
          wts_pkg::REG_TURN_KIND:      kind_r   = wts_pkg::turn_kind_t'(cfg_data[0]);
          wts_pkg::REG_TURN_DIRECTION: dir_r    = wts_pkg::turn_dir_t'(cfg_data[0]);
          wts_pkg::REG_TURN_AMOUNT:    amount_r = cfg_data[wts_pkg::AMOUNT_W-1:0];
          wts_pkg::REG_DRIVE_SPEED:    speed_r  = cfg_data[wts_pkg::SPEED_W-1:0];
          default: ;
        endcase
      end

      // input beat: advance odometry, latch base on a new turn, work out drives
      if (s_tvalid && s_tready) begin
        left_travel  = left_travel + angle_delta(prev_left, s_tdata[31:0]);
        prev_left    = s_tdata[31:0] & ANGLE_MASK[31:0];
        right_travel = right_travel + angle_delta(prev_right, s_tdata[63:32]);
        prev_right   = s_tdata[63:32] & ANGLE_MASK[31:0];
        if (!armed) begin
          left_base  = left_travel;
          right_base = right_travel;
          armed      = 1'b1;
        end

        spd = longint'((speed_r > wts_pkg::SPEED_MAX) ? wts_pkg::SPEED_MAX : speed_r);
        thr = longint'(amount_r);
        lt  = longint'($signed(left_travel));
        rt  = longint'($signed(right_travel));
        lb  = longint'($signed(left_base));
        rb  = longint'($signed(right_base));
        // exact compares, base +/- amount never wraps
        l_fwd  = lt > lb + thr;
        l_back = lt < lb - thr;
        r_fwd  = rt > rb + thr;
        r_back = rt < rb - thr;

        if (kind_r == wts_pkg::KIND_SPIN) begin
          if (dir_r == wts_pkg::DIR_RIGHT) begin
            ld   = l_fwd ? longint'(0) : spd;
            rd   = r_back ? longint'(0) : -spd;
            done = l_fwd && r_back;
          end else begin
            ld   = l_back ? longint'(0) : -spd;
            rd   = r_fwd ? longint'(0) : spd;
            done = l_back && r_fwd;
          end
        end else begin
          // pivot: the idle wheel is held at zero
          if (dir_r == wts_pkg::DIR_RIGHT) begin
            rd   = longint'(0);
            ld   = l_fwd ? longint'(0) : spd;
            done = l_fwd;
          end else begin
            ld   = longint'(0);
            rd   = r_fwd ? longint'(0) : spd;
            done = r_fwd;
          end
        end
        if (done)
          armed = 1'b0;

        want.left_drive  = ld[DRIVE_W-1:0];
        want.right_drive = rd[DRIVE_W-1:0];
        want.turn_done   = done;
        turn_result_q.push_back(want);
      end

      // result beat: compare with the oldest prediction
      if (m_tvalid && m_tready) begin
        got = wts_pkg::result_t'(m_tdata[16:0]);
        if (turn_result_q.size() == 0) begin
          $error("result beat with no prediction waiting: tdata %h", m_tdata);
          fails++;
        end else begin
          want = turn_result_q.pop_front();
          if (got.left_drive !== want.left_drive) begin
            $error("left_drive expected %0d got %0d", want.left_drive, got.left_drive);
            fails++;
          end
          if (got.right_drive !== want.right_drive) begin
            $error("right_drive expected %0d got %0d", want.right_drive, got.right_drive);
            fails++;
          end
          if (got.turn_done !== want.turn_done) begin
            $error("turn_done expected %0d got %0d", want.turn_done, got.turn_done);
            fails++;
          end
          if (m_tdata[23:17] !== 7'd0) begin
            $error("tdata padding expected %0d got %0d", 7'd0, m_tdata[23:17]);
            fails++;
          end
        end
      end
    end
    pending = turn_result_q.size();
  end

endmodule

FILE: bench/tb_top.sv
// testbench top: drives encoder beats and turn settings into the sequencer and gives the verdict
`timescale 1ns / 100ps

module tb_top;

  localparam int AMT_W = wts_pkg::AMOUNT_W;
  localparam int SPD_W = wts_pkg::SPEED_W;
  localparam int DAT_W = wts_pkg::CFG_DATA_W;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           cfg_we    = 1'b0;
  logic [wts_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [DAT_W-1:0]               cfg_data  = '0;
  logic                           s_tvalid  = 1'b0;
  logic                           s_tready;
  logic [63:0]                    s_tdata   = '0;   // left_angle [31:0], right_angle [63:32]
  logic                           m_tvalid;
  logic                           m_tready  = 1'b0;
  logic [23:0]                    m_tdata;  // left_drive [7:0], right_drive [15:8], turn_done [16]

  int bad_count;
  int open_count;
  int sink_wait = 0;
  bit src_quiet = 1'b0;
  bit snk_quiet = 1'b0;

  // 12 ns clock
  always #6 clk = ~clk;

  wheel_turn_sequencer #(.ANGLE_BITS(32)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  turn_checker #(.ANGLE_BITS(32)) turn_chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .fails     (bad_count),
    .pending   (open_count)
  );

  // result side: random stall after each accepted beat
  always @(posedge clk) begin : sink
    int draw;
    if (rst) begin
      m_tready  <= 1'b0;
      sink_wait <= 0;
    end else if (m_tready && m_tvalid) begin
      draw = snk_quiet ? 0 : $urandom_range(0, 7);
      m_tready  <= (draw == 0);
      sink_wait <= draw;
    end else if (!m_tready) begin
      if (sink_wait <= 1)
        m_tready <= 1'b1;
      sink_wait <= sink_wait - 1;
    end
  end

  // one encoder beat after a random gap, returns just after the accepting edge
  task automatic feed(input logic [31:0] la, input logic [31:0] ra);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ra, la};
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
  endtask

  // stop sending and wait until every predicted result has come back
  task automatic drain_results;
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (open_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input wts_pkg::reg_index_t idx, input logic [DAT_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  // new turn settings, written while the block is idle; spare bits carry junk
  task automatic set_turn(input wts_pkg::turn_kind_t kind, input wts_pkg::turn_dir_t dir,
                          input logic [AMT_W-1:0] amount, input logic [SPD_W-1:0] speed);
    logic [DAT_W-1:0] d;
    drain_results();
    d = DAT_W'($urandom);
    d[0] = kind;
    write_reg(wts_pkg::REG_TURN_KIND, d);
    d = DAT_W'($urandom);
    d[0] = dir;
    write_reg(wts_pkg::REG_TURN_DIRECTION, d);
    write_reg(wts_pkg::REG_TURN_AMOUNT, amount);
    d = DAT_W'($urandom);
    d[SPD_W-1:0] = speed;
    write_reg(wts_pkg::REG_DRIVE_SPEED, d);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    wts_pkg::turn_kind_t kind;
    wts_pkg::turn_dir_t  dir;
    logic [AMT_W-1:0]    amt;
    logic [SPD_W-1:0]    spd;
    logic [31:0]         la, ra;
    int                  pick, cap, lsign, rsign, sl, sr;
    la = '0;
    ra = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // spin right, zero amount: done as soon as both wheels move the way the turn drives them, angle extremes
    set_turn(wts_pkg::KIND_SPIN, wts_pkg::DIR_RIGHT, 16'd0, 7'd100);
    feed(32'd0, 32'd0);
    feed(32'd1, -32'sd1);
    feed(32'd0, 32'd0);
    feed(32'h7FFF_FFFF, 32'h8000_0000);
    feed(32'h8000_0000, 32'h7FFF_FFFF);
    feed(32'hFFFF_FFFF, 32'd0);
    feed(32'd0, 32'hFFFF_FFFF);

    // spin left, largest amount, speed above the cap
    set_turn(wts_pkg::KIND_SPIN, wts_pkg::DIR_LEFT, 16'hFFFF, 7'd127);
    feed(32'd0, 32'd0);
    feed(-32'sd65535, 32'd65535);
    feed(-32'sd65536, 32'd65536);
    feed(-32'sd65537, 32'd65537);
    feed(32'h7FFF_FFFF, 32'h7FFF_FFFF);

    // pivot right, tiny amount, zero speed
    set_turn(wts_pkg::KIND_PIVOT, wts_pkg::DIR_RIGHT, 16'd1, 7'd0);
    feed(32'd0, 32'd0);
    feed(32'd1, 32'd5);
    feed(32'd2, 32'd5);
    feed(32'd3, 32'd5);

    // pivot left, largest amount, slowest speed
    set_turn(wts_pkg::KIND_PIVOT, wts_pkg::DIR_LEFT, 16'hFFFF, 7'd1);
    feed(32'd0, 32'd0);
    feed(32'd0, 32'd40000);
    feed(32'd0, 32'd80000);
    feed(32'h1234_5678, 32'h9ABC_DEF0);
    feed(32'h5555_5555, 32'hAAAA_AAAA);

    // random phases: mostly wheels moving the way the turn drives them
    for (int ph = 0; ph < 10; ph++) begin
      kind = wts_pkg::turn_kind_t'($urandom_range(0, 1));
      dir  = wts_pkg::turn_dir_t'($urandom_range(0, 1));
      case (ph)
        0:       amt = 16'd0;
        1:       amt = 16'hFFFF;
        default: begin
          case ($urandom_range(0, 2))
            0:       amt = AMT_W'($urandom_range(0, 64));
            1:       amt = AMT_W'($urandom_range(0, 4095));
            default: amt = AMT_W'($urandom_range(0, 65535));
          endcase
        end
      endcase
      case (ph)
        2:       spd = 7'd0;
        3:       spd = 7'd127;
        4:       spd = 7'd100;
        default: spd = SPD_W'($urandom_range(0, 127));
      endcase
      src_quiet = ($urandom_range(0, 3) == 0);
      snk_quiet <= ($urandom_range(0, 3) == 0);
      set_turn(kind, dir, amt, spd);

      cap = amt / 4 + 4;
      if (kind == wts_pkg::KIND_SPIN) begin
        lsign = (dir == wts_pkg::DIR_RIGHT) ? 1 : -1;
        rsign = -lsign;
      end else begin
        lsign = (dir == wts_pkg::DIR_RIGHT) ? 1 : 0;
        rsign = (dir == wts_pkg::DIR_RIGHT) ? 0 : 1;
      end

      for (int i = 0; i < 160; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          sl = $urandom_range(0, cap);
          sr = $urandom_range(0, cap);
          // now and then a wheel slips back a little
          if ($urandom_range(0, 7) == 0)
            sl = -sl / 2;
          if ($urandom_range(0, 7) == 0)
            sr = -sr / 2;
          la = la + lsign * sl + int'($urandom_range(0, 4)) - 2;
          ra = ra + rsign * sr + int'($urandom_range(0, 4)) - 2;
        end else if (pick < 90) begin
          // large jumps that wrap the per-tick change
          la = la + $urandom;
          ra = ra + $urandom;
        end else begin
          la = $urandom;
          ra = $urandom;
        end
        feed(la, ra);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    if (bad_count == 0 && open_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // hard stop if the run hangs
  initial begin : watchdog
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

FILE: wheel_turn_sequencer.f
src/wts_pkg.sv
src/wheel_turn_sequencer.sv
bench/turn_checker.sv
bench/tb_top.sv
